@@ rtl/icosphere_triangle_subdivide_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ICOSPHERE_TRIANGLE_SUBDIVIDE_MACROS_SVH
`define ICOSPHERE_TRIANGLE_SUBDIVIDE_MACROS_SVH
// Implication checked on every clock, off during reset.
`define ITS_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked on every clock, off during reset.
`define ITS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/its_pkg.sv @@
// Shared types and constants of the triangle subdivider.
package its_pkg;
    localparam int INDEX_BITS = 24;
    localparam int COORD_BITS = 32;
    localparam int RADIUS_BITS = 31;
    localparam int CFG_BITS = 31;
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_INDEX = 1'd1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // One accepted triangle with its assigned new-vertex numbers.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [INDEX_BITS-1:0] ia, ib, ic, nab;
    } tri_word_t;
endpackage

@@ rtl/its_front.sv @@
// Front end: accepts triangles, numbers new vertices, queues words for the back end.
module its_front
    import its_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  tri_word_t in_word,
    input  logic idx_load,
    input  logic [INDEX_BITS-1:0] idx_value,
    output logic q_valid,
    input  logic q_take,
    output tri_word_t q_word
);
    // Two-entry queue.
    tri_word_t q_mem_reg [2];
    logic [1:0] q_cnt_reg;
    logic rd_ptr_reg, wr_ptr_reg;
    logic [INDEX_BITS-1:0] next_index_reg;
    logic push;
    tri_word_t w;

    assign in_stall = (q_cnt_reg == 2'd2);
    assign push = in_valid && !in_stall;
    assign q_valid = (q_cnt_reg != 2'd0);
    assign q_word = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        w = in_word;
        w.nab = next_index_reg;
    end

    // Queue storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= w;
        end
    end

    // Pointers, count and running vertex index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= 2'd0;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            next_index_reg <= INDEX_BITS'(12);
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, q_take};
            if (idx_load)
            begin
                next_index_reg <= idx_value;
            end
            else if (push)
            begin
                next_index_reg <= next_index_reg + INDEX_BITS'(3);
            end
        end
    end
endmodule

@@ rtl/its_math.sv @@
// Shared iterative unit: square root of a 64-bit value, or 63/32-bit division.
module its_math
    import its_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic is_sqrt,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic busy,
    output logic [31:0] result
);
    logic [63:0] rem_reg, rem_next;
    logic [32:0] acc_reg, acc_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] den_reg;
    logic [5:0] cnt_reg;
    logic mode_reg;
    logic busy_reg;
    logic [33:0] trial;
    logic [32:0] shifted;

    assign busy = busy_reg;
    assign result = res_reg;

    // One result bit per cycle: restoring square root or long division.
    always_comb
    begin
        rem_next = rem_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        trial = '0;
        shifted = '0;
        if (mode_reg)
        begin
            trial = {acc_reg[31:0], rem_reg[63:62]} - {res_reg, 2'b01};
            if (!trial[33])
            begin
                acc_next = trial[32:0];
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                acc_next = {acc_reg[30:0], rem_reg[63:62]};
                res_next = {res_reg[30:0], 1'b0};
            end
            rem_next = {rem_reg[61:0], 2'b00};
        end
        else
        begin
            shifted = {acc_reg[31:0], rem_reg[63]};
            trial = {1'b0, shifted} - {2'b00, den_reg};
            if (!trial[33])
            begin
                acc_next = trial[32:0];
                res_next = {res_reg[30:0], 1'b1};
            end
            else
            begin
                acc_next = shifted;
                res_next = {res_reg[30:0], 1'b0};
            end
            rem_next = {rem_reg[62:0], 1'b0};
        end
    end

    // A division starts with the upper 31 dividend bits as partial remainder,
    // which is below the divisor because the quotient fits 32 bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg <= is_sqrt;
            rem_reg <= is_sqrt ? num : {num[31:0], 32'd0};
            acc_reg <= is_sqrt ? 33'd0 : {2'b00, num[62:32]};
            res_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end
endmodule

@@ rtl/its_back.sv @@
// Back end: computes three projected vertices and emits seven output words.
module its_back
    import its_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic [RADIUS_BITS-1:0] radius,
    input  logic q_valid,
    output logic q_take,
    input  tri_word_t q_word,
    output logic out_valid,
    input  logic out_stall,
    output logic kind,
    output logic signed [COORD_BITS-1:0] coord_x,
    output logic signed [COORD_BITS-1:0] coord_y,
    output logic signed [COORD_BITS-1:0] coord_z,
    output logic [INDEX_BITS-1:0] vertex_number,
    output logic [INDEX_BITS-1:0] corner_first,
    output logic [INDEX_BITS-1:0] corner_second,
    output logic [INDEX_BITS-1:0] corner_third,
    output logic last_of_run
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MID = 4'd1;
    localparam logic [3:0] S_SQ = 4'd2;
    localparam logic [3:0] S_SUM = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_MUL = 4'd5;
    localparam logic [3:0] S_DIV = 4'd6;
    localparam logic [3:0] S_VOUT = 4'd7;
    localparam logic [3:0] S_TOUT = 4'd8;

    logic [3:0] state_reg;
    logic [1:0] edge_reg;
    logic [1:0] comp_reg;
    tri_word_t t_reg;
    logic signed [COORD_BITS-1:0] m_reg [3];
    logic [63:0] sq_reg [3];
    logic [63:0] sum_w;
    logic [31:0] len_reg;
    logic [62:0] prod_w;
    logic [31:0] c_reg [3];
    logic ovalid_reg;
    logic signed [COORD_BITS-1:0] p [3];
    logic signed [COORD_BITS-1:0] q [3];
    logic [31:0] mag [3];
    logic [32:0] sum33 [3];
    logic [INDEX_BITS-1:0] nbc, nca;
    logic ustart, uis_sqrt, ubusy;
    logic [63:0] unum;
    logic [31:0] ures;
    logic [31:0] quot_signed;
    logic out_free;
    logic out_load;

    assign nbc = t_reg.nab + INDEX_BITS'(1);
    assign nca = t_reg.nab + INDEX_BITS'(2);
    assign out_free = !ovalid_reg || !out_stall;
    assign out_load = (state_reg == S_VOUT || state_reg == S_TOUT) && out_free;
    assign out_valid = ovalid_reg;
    assign q_take = (state_reg == S_IDLE) && q_valid;

    // Edge endpoints: a-b, b-c, c-a.
    always_comb
    begin
        case (edge_reg)
            2'd0:
            begin
                p[0] = t_reg.ax; p[1] = t_reg.ay; p[2] = t_reg.az;
                q[0] = t_reg.bx; q[1] = t_reg.by; q[2] = t_reg.bz;
            end
            2'd1:
            begin
                p[0] = t_reg.bx; p[1] = t_reg.by; p[2] = t_reg.bz;
                q[0] = t_reg.cx; q[1] = t_reg.cy; q[2] = t_reg.cz;
            end
            default:
            begin
                p[0] = t_reg.cx; p[1] = t_reg.cy; p[2] = t_reg.cz;
                q[0] = t_reg.ax; q[1] = t_reg.ay; q[2] = t_reg.az;
            end
        endcase
        for (int i = 0; i < 3; i++)
        begin
            sum33[i] = {p[i][31], p[i]} + {q[i][31], q[i]};
            mag[i] = m_reg[i][31] ? 32'(-m_reg[i]) : 32'(m_reg[i]);
        end
    end

    // Operands go straight into the iterative unit as it starts. A zero
    // length also runs the square root, which then yields zero.
    assign sum_w = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign prod_w = 63'(mag[comp_reg]) * 63'(radius);
    assign uis_sqrt = (state_reg == S_SUM);
    assign ustart = (state_reg == S_SUM) || (state_reg == S_MUL);
    assign unum = (state_reg == S_SUM) ? sum_w : {1'b0, prod_w};
    assign quot_signed = m_reg[comp_reg][31] ? (32'd0 - ures) : ures;

    its_math u_math (
        .clk(clk), .rst_n(rst_n), .start(ustart), .is_sqrt(uis_sqrt),
        .num(unum), .den(len_reg), .busy(ubusy), .result(ures)
    );

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            t_reg <= q_word;
        end
        if (state_reg == S_MID)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= sum33[i][32:1];
            end
        end
        if (state_reg == S_SQ)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= 64'(mag[i]) * 64'(mag[i]);
            end
        end
        if (state_reg == S_SQRT && !ubusy)
        begin
            len_reg <= ures;
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= '0;
            end
        end
        if (state_reg == S_DIV && !ubusy)
        begin
            c_reg[comp_reg] <= quot_signed;
        end
        if (out_load)
        begin
            kind <= (state_reg == S_TOUT) ? KIND_TRIANGLE : KIND_VERTEX;
            last_of_run <= (state_reg == S_TOUT) && (edge_reg == 2'd3);
            if (state_reg == S_VOUT)
            begin
                coord_x <= (len_reg == 32'd0) ? '0 : c_reg[0];
                coord_y <= (len_reg == 32'd0) ? '0 : c_reg[1];
                coord_z <= (len_reg == 32'd0) ? '0 : c_reg[2];
                vertex_number <= t_reg.nab + INDEX_BITS'(edge_reg);
                corner_first <= '0;
                corner_second <= '0;
                corner_third <= '0;
            end
            else
            begin
                coord_x <= '0;
                coord_y <= '0;
                coord_z <= '0;
                vertex_number <= '0;
                case (edge_reg)
                    2'd0:
                    begin
                        corner_first <= t_reg.ia; corner_second <= t_reg.nab;
                        corner_third <= nca;
                    end
                    2'd1:
                    begin
                        corner_first <= t_reg.ib; corner_second <= nbc;
                        corner_third <= t_reg.nab;
                    end
                    2'd2:
                    begin
                        corner_first <= t_reg.ic; corner_second <= nca;
                        corner_third <= nbc;
                    end
                    default:
                    begin
                        corner_first <= t_reg.nab; corner_second <= nbc;
                        corner_third <= nca;
                    end
                endcase
            end
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            edge_reg <= '0;
            comp_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_MID;
                        edge_reg <= 2'd0;
                    end
                end
                S_MID: state_reg <= S_SQ;
                S_SQ: state_reg <= S_SUM;
                S_SUM: state_reg <= S_SQRT;
                S_SQRT:
                begin
                    if (!ubusy)
                    begin
                        comp_reg <= 2'd0;
                        state_reg <= (ures == 32'd0) ? S_VOUT : S_MUL;
                    end
                end
                S_MUL: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (!ubusy)
                    begin
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= S_VOUT;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_VOUT:
                begin
                    if (out_free)
                    begin
                        if (edge_reg == 2'd2)
                        begin
                            edge_reg <= 2'd0;
                            state_reg <= S_TOUT;
                        end
                        else
                        begin
                            edge_reg <= edge_reg + 2'd1;
                            state_reg <= S_MID;
                        end
                    end
                end
                S_TOUT:
                begin
                    if (out_free)
                    begin
                        edge_reg <= edge_reg + 2'd1;
                        if (edge_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/icosphere_triangle_subdivide.sv @@
// Top level of the icosphere triangle subdivider.
//  channel | signals                                   | word
//  in      | in_valid / in_stall                       | one triangle, 3 corners + indices
//  out     | out_valid / out_stall                     | one vertex or child triangle record
//  config  | cfg_write / cfg_index / cfg_data          | radius, start index
// Each new vertex takes a square root and, unless its length is zero, three multiply-divides on
// the shared iterative unit; output stalls lengthen the back-end work on a triangle.
// Seven words leave per triangle; a two-entry queue lets input be taken meanwhile.
// Reset restores radius 50.0 and start index 12; no clearing pass is needed.
// A stalled output holds its word; the sequencer waits for it.
module icosphere_triangle_subdivide
    import its_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
    input  logic [INDEX_BITS-1:0] index_a, index_b, index_c,
    output logic out_valid,
    input  logic out_stall,
    output logic kind,
    output logic signed [COORD_BITS-1:0] coord_x, coord_y, coord_z,
    output logic [INDEX_BITS-1:0] vertex_number,
    output logic [INDEX_BITS-1:0] corner_first, corner_second, corner_third,
    output logic last_of_run
);
    logic [RADIUS_BITS-1:0] radius_reg;
    tri_word_t in_word, q_word;
    logic q_valid, q_take, idx_load;

    assign idx_load = cfg_write && (cfg_index == REG_START_INDEX);

    // Radius register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_BITS'(3276800);
        end
        else if (cfg_write && cfg_index == REG_RADIUS)
        begin
            radius_reg <= cfg_data;
        end
    end

    always_comb
    begin
        in_word = '{ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz, cx: cx, cy: cy,
                    cz: cz, ia: index_a, ib: index_b, ic: index_c, nab: '0};
    end

    its_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_word), .idx_load(idx_load), .idx_value(cfg_data[INDEX_BITS-1:0]),
        .q_valid(q_valid), .q_take(q_take), .q_word(q_word)
    );

    its_back u_back (
        .clk(clk), .rst_n(rst_n), .radius(radius_reg), .q_valid(q_valid),
        .q_take(q_take), .q_word(q_word), .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .vertex_number(vertex_number), .corner_first(corner_first),
        .corner_second(corner_second), .corner_third(corner_third),
        .last_of_run(last_of_run)
    );
endmodule

@@ rtl/its_checker.sv @@
// Port-level checker for the subdivider, bound to the top level.
`include "icosphere_triangle_subdivide_macros.svh"
module its_checker
    import its_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic kind,
    input logic last_of_run,
    input logic signed [COORD_BITS-1:0] coord_x,
    input logic [INDEX_BITS-1:0] corner_first
);
    `ITS_ASSERT_IMPL(a_last_is_tri, clk, rst_n, out_valid && last_of_run, kind == KIND_TRIANGLE, "last word not a triangle")
    `ITS_ASSERT_IMPL(a_vertex_no_corner, clk, rst_n, out_valid && kind == KIND_VERTEX, corner_first == '0 && !last_of_run, "vertex word has corners")
    `ITS_ASSERT_IMPL(a_tri_no_coord, clk, rst_n, out_valid && kind == KIND_TRIANGLE, coord_x == '0, "triangle word has coordinate")
    `ITS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(kind), "stalled word changed")
endmodule

bind icosphere_triangle_subdivide its_checker u_its_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .last_of_run(last_of_run), .coord_x(coord_x),
    .corner_first(corner_first)
);
